// ----- design/dqs_pkg.sv -----
// Shared types, command codes, status codes and cell operations for the deque.
`timescale 1ns / 1ps

package dqs_pkg;

    typedef logic signed [31:0] word_t;

    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_SEARCH     = 3'd4;
    localparam logic [2:0] CMD_DUMP       = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [2:0] OP_HOLD       = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
    localparam logic [2:0] OP_SHIFT_LEFT = 3'd3;
    localparam logic [2:0] OP_POP_BACK   = 3'd4;
    localparam logic [2:0] OP_ROTATE     = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        word_t      value;
        word_t      key;
    } cell_ctrl_t;

endpackage

// ----- design/dqs_cell.sv -----
// One storage cell of the deque chain, with its occupancy bit and key comparator.
`timescale 1ns / 1ps

module dqs_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  dqs_pkg::cell_ctrl_t ctrl,
    input  dqs_pkg::word_t     left_data,
    input  logic               left_occ,
    input  dqs_pkg::word_t     right_data,
    input  logic               right_occ,
    input  dqs_pkg::word_t     front_data,
    output dqs_pkg::word_t     data,
    output logic               occ,
    output logic               match,
    output logic               tail
);

    dqs_pkg::word_t data_reg;
    dqs_pkg::word_t data_next;
    logic           occ_reg;
    logic           occ_next;

    assign data  = data_reg;
    assign occ   = occ_reg;
    assign tail  = occ_reg && !right_occ;
    assign match = occ_reg && (data_reg == ctrl.key);

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        unique case (ctrl.op)
            dqs_pkg::OP_PUSH_BACK:
            begin
                if (!occ_reg && left_occ)
                begin
                    data_next = ctrl.value;
                    occ_next  = 1'b1;
                end
            end
            dqs_pkg::OP_PUSH_FRONT:
            begin
                data_next = left_data;
                occ_next  = left_occ;
            end
            dqs_pkg::OP_SHIFT_LEFT:
            begin
                data_next = right_data;
                occ_next  = right_occ;
            end
            dqs_pkg::OP_POP_BACK:
            begin
                occ_next = occ_reg && right_occ;
            end
            dqs_pkg::OP_ROTATE:
            begin
                data_next = (occ_reg && !right_occ) ? front_data : right_data;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ----- design/dqs_find.sv -----
// First-match position encoder and tail-entry selector over the cell chain.
`timescale 1ns / 1ps

module dqs_find
#(
    parameter int DEPTH = 16,
    parameter int PW    = 5
)
(
    input  logic [DEPTH-1:0]   match_vec,
    input  logic [DEPTH-1:0]   tail_vec,
    input  dqs_pkg::word_t     cell_data [DEPTH],
    output logic               hit,
    output logic [PW-1:0]      pos,
    output dqs_pkg::word_t     tail_data
);

    always_comb
    begin
        hit = 1'b0;
        pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                hit = 1'b1;
                pos = PW'(i + 1);
            end
        end
    end

    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_data = tail_data | (cell_data[i] & {32{tail_vec[i]}});
        end
    end

endmodule

// ----- design/deque_with_search_unit.sv -----
// Top level of the bounded double-ended queue with key search.
`timescale 1ns / 1ps

// The deque keeps up to DEPTH signed 32-bit entries in a chain of cells, front
// in cell 0. Push back, push front, pop front, pop back, search and unused
// command codes each give one result word in the next cycle through the
// output register, so these commands sustain one word per cycle when the
// result side does not stall. A dump gives one result word per stored entry,
// because the chain rotates by one cell per result word to bring each entry
// to the front; the next word is taken after the last dump result has been
// loaded. Search compares all cells in parallel and encodes the first match
// in the same cycle.

module deque_with_search_unit
#(
    parameter int DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [2:0]                        cmd,
    input  dqs_pkg::word_t                    value,
    input  dqs_pkg::word_t                    key,
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [1:0]                        status,
    output dqs_pkg::word_t                    data,
    output logic [$clog2(DEPTH + 1)-1:0]      position,
    output logic [$clog2(DEPTH + 1)-1:0]      occupancy,
    output logic                              last
);

    localparam int FW = $clog2(DEPTH + 1);

    dqs_pkg::word_t      cell_data [DEPTH];
    logic [DEPTH-1:0]    cell_occ;
    logic [DEPTH-1:0]    match_vec;
    logic [DEPTH-1:0]    tail_vec;
    dqs_pkg::cell_ctrl_t ctrl;
    logic                hit;
    logic [FW-1:0]       hit_pos;
    dqs_pkg::word_t      tail_data;

    logic                result_valid_reg;
    logic [1:0]          status_reg;
    dqs_pkg::word_t      data_reg;
    logic [FW-1:0]       position_reg;
    logic [FW-1:0]       occupancy_reg;
    logic                last_reg;
    logic                dump_reg;
    logic                dump_next;
    logic [FW-1:0]       cnt_reg;
    logic [FW-1:0]       cnt_next;
    logic [FW-1:0]       fill_reg;
    logic [FW-1:0]       fill_next;

    logic                can_load;
    logic                accept;
    logic                emit;
    logic                is_full;
    logic                is_empty;
    logic [1:0]          st;
    dqs_pkg::word_t      dat;
    logic [FW-1:0]       pos;
    logic                lst;
    logic [FW-1:0]       cnt_inc;

    assign can_load   = !result_valid_reg || !result_stall;
    assign item_stall = dump_reg || !can_load;
    assign accept     = item_valid && !item_stall;
    assign is_full    = (fill_reg == FW'(DEPTH));
    assign is_empty   = (fill_reg == '0);
    assign cnt_inc    = cnt_reg + FW'(1);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            dqs_pkg::word_t l_data;
            logic           l_occ;
            dqs_pkg::word_t r_data;
            logic           r_occ;

            if (g == 0)
            begin : g_first
                assign l_data = value;
                assign l_occ  = 1'b1;
            end
            else
            begin : g_mid
                assign l_data = cell_data[g-1];
                assign l_occ  = cell_occ[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_end
                assign r_data = cell_data[0];
                assign r_occ  = 1'b0;
            end
            else
            begin : g_inner
                assign r_data = cell_data[g+1];
                assign r_occ  = cell_occ[g+1];
            end

            dqs_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_data  (l_data),
                .left_occ   (l_occ),
                .right_data (r_data),
                .right_occ  (r_occ),
                .front_data (cell_data[0]),
                .data       (cell_data[g]),
                .occ        (cell_occ[g]),
                .match      (match_vec[g]),
                .tail       (tail_vec[g])
            );
        end
    endgenerate

    dqs_find
    #(
        .DEPTH (DEPTH),
        .PW    (FW)
    )
    u_find
    (
        .match_vec (match_vec),
        .tail_vec  (tail_vec),
        .cell_data (cell_data),
        .hit       (hit),
        .pos       (hit_pos),
        .tail_data (tail_data)
    );

    always_comb
    begin
        ctrl.value = value;
        ctrl.key   = key;
        ctrl.op    = dqs_pkg::OP_HOLD;
        fill_next = fill_reg;
        dump_next = dump_reg;
        cnt_next  = cnt_reg;
        emit      = 1'b0;
        st        = dqs_pkg::ST_OK;
        dat       = '0;
        pos       = '0;
        lst       = 1'b1;
        if (dump_reg)
        begin
            if (can_load)
            begin
                emit    = 1'b1;
                ctrl.op = dqs_pkg::OP_ROTATE;
                dat     = cell_data[0];
                lst     = (cnt_inc == fill_reg);
                cnt_next = cnt_inc;
                if (lst)
                begin
                    dump_next = 1'b0;
                end
            end
        end
        else if (accept)
        begin
            emit = 1'b1;
            unique case (cmd)
                dqs_pkg::CMD_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        st = dqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.op   = dqs_pkg::OP_PUSH_BACK;
                        fill_next = fill_reg + FW'(1);
                    end
                end
                dqs_pkg::CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        st = dqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.op   = dqs_pkg::OP_PUSH_FRONT;
                        fill_next = fill_reg + FW'(1);
                    end
                end
                dqs_pkg::CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        st = dqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op   = dqs_pkg::OP_SHIFT_LEFT;
                        dat       = cell_data[0];
                        fill_next = fill_reg - FW'(1);
                    end
                end
                dqs_pkg::CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        st = dqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.op   = dqs_pkg::OP_POP_BACK;
                        dat       = tail_data;
                        fill_next = fill_reg - FW'(1);
                    end
                end
                dqs_pkg::CMD_SEARCH:
                begin
                    if (hit)
                    begin
                        pos = hit_pos;
                    end
                    else
                    begin
                        st = dqs_pkg::ST_NOTFOUND;
                    end
                end
                dqs_pkg::CMD_DUMP:
                begin
                    if (is_empty)
                    begin
                        st = dqs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        emit      = 1'b0;
                        dump_next = 1'b1;
                        cnt_next  = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            dump_reg         <= 1'b0;
            cnt_reg          <= '0;
            fill_reg         <= '0;
        end
        else
        begin
            if (can_load)
            begin
                result_valid_reg <= emit;
            end
            dump_reg <= dump_next;
            cnt_reg  <= cnt_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg    <= st;
            data_reg      <= dat;
            position_reg  <= pos;
            occupancy_reg <= fill_next;
            last_reg      <= lst;
        end
    end

    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign data         = data_reg;
    assign position     = position_reg;
    assign occupancy    = occupancy_reg;
    assign last         = last_reg;

endmodule

// ----- design/dqs_checker.sv -----
// Port-level assertions for the deque, bound to the top level.
`timescale 1ns / 1ps

module dqs_checker
#(
    parameter int DEPTH = 16
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         result_valid,
    input logic                         result_stall,
    input logic [1:0]                   status,
    input dqs_pkg::word_t               data,
    input logic [$clog2(DEPTH + 1)-1:0] position,
    input logic [$clog2(DEPTH + 1)-1:0] occupancy,
    input logic                         last
);

    localparam int FW = $clog2(DEPTH + 1);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(data) && $stable(status))
        else $error("Stalled result word changed.");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> occupancy <= FW'(DEPTH))
        else $error("Occupancy exceeds depth.");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != dqs_pkg::ST_OK |-> last && data == '0 && position == '0)
        else $error("Error result word is not a clean single word.");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == dqs_pkg::ST_FULL |-> occupancy == FW'(DEPTH))
        else $error("Full status with queue not full.");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == dqs_pkg::ST_EMPTY |-> occupancy == '0)
        else $error("Empty status with entries stored.");

endmodule

bind deque_with_search_unit dqs_checker #(.DEPTH(DEPTH)) u_dqs_checker (.*);
